// File: hw/rtl/cartridge_bank_mapper_assert.svh
// ----------------------------------------------------------------------------
// Cartridge bank mapper assertion macros
// Shared property templates for the mapper's concurrent checks. Each macro
// expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Word types, register addresses, operation codes and the bank reload
// function shared by the mapper logic.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int PATTERN_SLOTS = 8;
  localparam int PROGRAM_SLOTS = 4;

  // Operation codes of an input word.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CHR   = 2'd1;
  localparam logic [1:0] OP_PRG   = 2'd2;

  // Mapper register addresses in CPU space.
  localparam logic [15:0] ADDR_CHR2K_0 = 16'h7EF0;
  localparam logic [15:0] ADDR_CHR2K_1 = 16'h7EF1;
  localparam logic [15:0] ADDR_CHR1K_0 = 16'h7EF2;
  localparam logic [15:0] ADDR_CHR1K_1 = 16'h7EF3;
  localparam logic [15:0] ADDR_CHR1K_2 = 16'h7EF4;
  localparam logic [15:0] ADDR_CHR1K_3 = 16'h7EF5;
  localparam logic [15:0] ADDR_CTRL    = 16'h7EF6;
  localparam logic [15:0] ADDR_PRG_0   = 16'h7EFA;
  localparam logic [15:0] ADDR_PRG_1   = 16'h7EFB;
  localparam logic [15:0] ADDR_PRG_2   = 16'h7EFC;

  // Configuration register indexes.
  localparam logic CFG_CHR_UNITS = 1'b0;
  localparam logic CFG_PRG_UNITS = 1'b1;

  localparam logic [5:0] UNITS_RESET = 6'd16;

  typedef logic [7:0] chr_page_t;
  typedef logic [5:0] prg_page_t;
  typedef prg_page_t [PROGRAM_SLOTS-1:0] prg_pages_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [18:0] rom_address;
    logic        mirror_vertical;
    logic        accepted;
  } out_word_t;

  // Program pages after a reload: first two pages, then the last two.
  function automatic prg_pages_t reload_program_pages(input logic [5:0] units);
    logic [6:0] count;
    prg_pages_t pages;
    count    = {units, 1'b0};
    pages[0] = '0;
    pages[1] = (count >= 7'd2) ? 6'd1 : 6'd0;
    pages[2] = (count >= 7'd2) ? 6'(count - 7'd2) : 6'd0;
    pages[3] = (count != 7'd0) ? 6'(count - 7'd1) : 6'd0;
    return pages;
  endfunction

endpackage

// File: hw/rtl/cartridge_bank_mapper.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper
// Translates pattern and program addresses to ROM byte addresses and takes
// bank register writes, reducing page numbers modulo the ROM page count.
// ----------------------------------------------------------------------------
// Path: a translate word goes from the held-word register through the finish
// state into the output register; a register write first runs its page number
// through an 8-step shift-subtract remainder unit, one bit per cycle.
// Flow: one word in flight; the next is taken once the current word has moved
// into the output register, which waits while a held result is stalled.
// Reset (synchronous, rst_n low): both size registers return to 16 and the
// bank state is reloaded; the APB port writes reload the bank state as well.
module cartridge_bank_mapper
  import cbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Input word channel
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  // Result word channel
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  // Configuration port
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Control and configuration.
  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [5:0] chr_units_r, chr_units_nxt;
  logic [5:0] prg_units_r, prg_units_nxt;

  // Bank state.
  chr_page_t  pat_page_r [PATTERN_SLOTS];
  chr_page_t  pat_page_nxt [PATTERN_SLOTS];
  prg_pages_t prg_page_r, prg_page_nxt;
  logic       swap_r, swap_nxt;
  logic       mirror_r, mirror_nxt;

  // Word held while it is worked on.
  in_word_t   item_r, item_nxt;

  // Remainder unit: dividend shifts out MSB first into the partial remainder.
  logic [7:0] dvd_r, dvd_nxt;
  logic [8:0] div_r, div_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [9:0] trial;
  logic       trial_ge;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;

  logic       in_fire;
  logic       cfg_wr;
  logic       finish;
  logic       is_prg_reg;
  logic [7:0] page_val;
  logic [2:0] slot_2k;
  logic [2:0] slot_1k;
  logic       hit;
  logic [18:0] rom_addr;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign prdata    = (paddr[2] == CFG_PRG_UNITS) ? {26'd0, prg_units_r}
                                                 : {26'd0, chr_units_r};

  // A word leaves the unit once the output register is free or being drained.
  assign finish = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // Program bank registers use the program page count as the modulus.
  assign is_prg_reg = (in_data.address == ADDR_PRG_0) ||
                      (in_data.address == ADDR_PRG_1) ||
                      (in_data.address == ADDR_PRG_2);

  assign trial    = {rem_r, dvd_r[7]};
  assign trial_ge = (trial >= {1'b0, div_r});

  // A zero page count forces the reduced page number to zero.
  assign page_val = (div_r == 9'd0) ? 8'd0 : rem_r[7:0];

  assign slot_2k = (swap_r ? 3'd4 : 3'd0) +
                   ((item_r.address == ADDR_CHR2K_1) ? 3'd2 : 3'd0);
  assign slot_1k = (swap_r ? 3'd0 : 3'd4) + {1'b0, 2'(item_r.address - ADDR_CHR1K_0)};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    chr_units_nxt = chr_units_r;
    prg_units_nxt = prg_units_r;
    pat_page_nxt  = pat_page_r;
    prg_page_nxt  = prg_page_r;
    swap_nxt      = swap_r;
    mirror_nxt    = mirror_r;
    item_nxt      = item_r;
    dvd_nxt       = dvd_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    hit           = 1'b0;
    rom_addr      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          cnt_nxt  = 3'd7;
          rem_nxt  = '0;
          if (is_prg_reg) begin
            dvd_nxt = {2'b00, in_data.write_data[7:2]};
            div_nxt = {2'b00, prg_units_r, 1'b0};
          end else if (in_data.address == ADDR_CHR2K_0 ||
                       in_data.address == ADDR_CHR2K_1) begin
            dvd_nxt = {in_data.write_data[7:1], 1'b0};
            div_nxt = {chr_units_r, 3'b000};
          end else begin
            dvd_nxt = in_data.write_data;
            div_nxt = {chr_units_r, 3'b000};
          end
          state_nxt = (in_data.operation == OP_WRITE) ? ST_DIVIDE : ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        rem_nxt = trial_ge ? 9'(trial - {1'b0, div_r}) : trial[8:0];
        dvd_nxt = {dvd_r[6:0], 1'b0};
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish) begin
          unique case (item_r.operation)
            OP_WRITE: begin
              unique case (item_r.address)
                ADDR_CHR2K_0, ADDR_CHR2K_1: begin
                  pat_page_nxt[slot_2k]        = page_val;
                  pat_page_nxt[slot_2k + 3'd1] = page_val + 8'd1;
                  hit = 1'b1;
                end
                ADDR_CHR1K_0, ADDR_CHR1K_1, ADDR_CHR1K_2, ADDR_CHR1K_3: begin
                  pat_page_nxt[slot_1k] = page_val;
                  hit = 1'b1;
                end
                ADDR_CTRL: begin
                  swap_nxt   = item_r.write_data[1];
                  mirror_nxt = item_r.write_data[0];
                  hit = 1'b1;
                end
                ADDR_PRG_0, ADDR_PRG_1, ADDR_PRG_2: begin
                  prg_page_nxt[2'(item_r.address - ADDR_PRG_0)] = page_val[5:0];
                  hit = 1'b1;
                end
                default: hit = 1'b0;
              endcase
            end
            OP_CHR: begin
              if (item_r.address < 16'h2000) begin
                rom_addr = {1'b0, pat_page_r[item_r.address[12:10]],
                            item_r.address[9:0]};
                hit = 1'b1;
              end
            end
            OP_PRG: begin
              if (item_r.address[15]) begin
                rom_addr = {prg_page_r[item_r.address[14:13]], item_r.address[12:0]};
                hit = 1'b1;
              end
            end
            default: hit = 1'b0;
          endcase
          out_valid_nxt                = 1'b1;
          out_data_nxt.rom_address     = rom_addr;
          out_data_nxt.mirror_vertical = mirror_nxt;
          out_data_nxt.accepted        = hit;
          state_nxt                    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // A size register write stores the value and reloads all bank state.
    if (cfg_wr) begin
      if (paddr[2] == CFG_PRG_UNITS) begin
        prg_units_nxt = pwdata[5:0];
        prg_page_nxt  = reload_program_pages(pwdata[5:0]);
      end else begin
        chr_units_nxt = pwdata[5:0];
        prg_page_nxt  = reload_program_pages(prg_units_r);
      end
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
        pat_page_nxt[i] = chr_page_t'(i);
      end
      swap_nxt   = 1'b0;
      mirror_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      chr_units_r <= UNITS_RESET;
      prg_units_r <= UNITS_RESET;
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
        pat_page_r[i] <= chr_page_t'(i);
      end
      prg_page_r  <= reload_program_pages(UNITS_RESET);
      swap_r      <= 1'b0;
      mirror_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chr_units_r <= chr_units_nxt;
      prg_units_r <= prg_units_nxt;
      pat_page_r  <= pat_page_nxt;
      prg_page_r  <= prg_page_nxt;
      swap_r      <= swap_nxt;
      mirror_r    <= mirror_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    dvd_r      <= dvd_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  `include "cartridge_bank_mapper_assert.svh"

  `CBM_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall,
    "mapper took a word but did not go busy")
  `CBM_ASSERT_SAME(a_reject_zero_addr, out_valid_r && !out_data_r.accepted,
    out_data_r.rom_address == 19'd0, "rejected word carries a ROM address")
  `CBM_ASSERT_SAME(a_load_from_finish, $rose(out_valid_r),
    $past(state_r == ST_FINISH), "result appeared without a finishing word")
  `CBM_ASSERT_NEXT(a_mirror_stable, !finish && !cfg_wr, $stable(mirror_r),
    "mirroring changed without a write")

endmodule

// File: test/tb_cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper testbench
// Drives translate and bank register words through the mapper under random
// valid/stall pacing and checks every result word, in order, against its typed
// row or a bank-state predictor kept in step with the words and the size registers.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper;
  import cbm_pkg::*;

  // Operation code that the mapper treats as a no-op.
  localparam logic [1:0] OP_NONE = 2'd3;
  // Pattern space ends here; program space starts at the top half of CPU space.
  localparam logic [15:0] CHR_SPACE_END = 16'h2000;

  localparam int PHASES        = 8;
  localparam int ITEMS_PER_PH  = 205;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 500000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cartridge_bank_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // A row of the directed table. When has_fixed is set the expected word is
  // the one typed into the row; otherwise it comes from the bank predictor.
  typedef struct packed {
    in_word_t  word;
    logic      has_fixed;
    out_word_t fixed;
  } dir_row_t;

  dir_row_t  dir_rows[$];
  out_word_t expected_words[$];

  // Predicted mapper state: size registers and the live bank pages.
  logic [5:0] chr_units;
  logic [5:0] prg_units;
  logic [7:0] chr_pg [0:7];
  logic [5:0] prg_pg [0:3];
  logic       swap_q;
  logic       vmir_q;

  // The fixed expectation travels with the word so that the checker sees
  // the one that belongs to the word it is accepting.
  logic      cur_fixed_en;
  out_word_t cur_fixed;

  // Receiver pacing: the random per-word stall and the long hold-off are
  // kept apart and merged onto the stall input.
  logic rx_stall;
  logic hold_off;
  bit   start_hold;
  bit   tx_idle;
  bit   rx_idle;

  int errors;
  int words_checked;
  int cycles;

  assign out_stall = rx_stall | hold_off;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bank predictor
  // --------------------------------------------------------------------------

  function automatic int mod_pages(input int v, input int count);
    return (count == 0) ? 0 : v % count;
  endfunction

  // Bank state as it stands after reset or after any size register write.
  function automatic void reload_banks();
    int cnt;
    cnt = int'(prg_units) * 2;
    for (int i = 0; i < PATTERN_SLOTS; i++) chr_pg[i] = 8'(i);
    prg_pg[0] = 6'd0;
    prg_pg[1] = (cnt >= 2) ? 6'd1 : 6'd0;
    prg_pg[2] = (cnt >= 2) ? 6'(cnt - 2) : 6'd0;
    prg_pg[3] = (cnt != 0) ? 6'(cnt - 1) : 6'd0;
    swap_q = 1'b0;
    vmir_q = 1'b1;
  endfunction

  function automatic bit bank_write(input logic [15:0] addr, input logic [7:0] data);
    int chr_cnt;
    int prg_cnt;
    int p;
    int slot;
    chr_cnt = int'(chr_units) * 8;
    prg_cnt = int'(prg_units) * 2;
    case (addr)
      ADDR_CHR2K_0, ADDR_CHR2K_1: begin
        // The 2K banks drop bit 0 and fill two adjacent 1K slots.
        p = mod_pages(int'(data & 8'hFE), chr_cnt);
        slot = (swap_q ? 4 : 0) + ((addr == ADDR_CHR2K_1) ? 2 : 0);
        chr_pg[slot & 7] = 8'(p);
        chr_pg[(slot + 1) & 7] = 8'(p + 1);
        return 1'b1;
      end
      ADDR_CHR1K_0, ADDR_CHR1K_1, ADDR_CHR1K_2, ADDR_CHR1K_3: begin
        p = mod_pages(int'(data), chr_cnt);
        slot = (swap_q ? 0 : 4) + int'(addr - ADDR_CHR1K_0);
        chr_pg[slot & 7] = 8'(p);
        return 1'b1;
      end
      ADDR_CTRL: begin
        swap_q = data[1];
        vmir_q = data[0];
        return 1'b1;
      end
      ADDR_PRG_0, ADDR_PRG_1, ADDR_PRG_2: begin
        p = mod_pages(int'(data >> 2), prg_cnt);
        prg_pg[int'(addr - ADDR_PRG_0) & 3] = 6'(p);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic out_word_t map_word(input in_word_t w);
    out_word_t r;
    r = '0;
    case (w.operation)
      OP_WRITE: r.accepted = bank_write(w.address, w.write_data);
      OP_CHR: begin
        if (w.address < CHR_SPACE_END) begin
          r.rom_address = {1'b0, chr_pg[w.address[12:10]], w.address[9:0]};
          r.accepted = 1'b1;
        end
      end
      OP_PRG: begin
        if (w.address[15]) begin
          r.rom_address = {prg_pg[w.address[14:13]], w.address[12:0]};
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    // Mirroring is reported as it stands after this word.
    r.mirror_vertical = vmir_q;
    return r;
  endfunction

  function automatic void apply_size(input logic idx, input logic [31:0] value);
    if (idx == CFG_CHR_UNITS) chr_units = value[5:0];
    else prg_units = value[5:0];
    reload_banks();
  endfunction

  // --------------------------------------------------------------------------
  // Checker: everything is sampled at the rising edge, before the block's
  // own updates of that edge land, so the sampled values are the ones the
  // block acted on.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t pred;
    if (!rst_n) begin
      chr_units = UNITS_RESET;
      prg_units = UNITS_RESET;
      reload_banks();
      expected_words.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          apply_size(paddr[2], pwdata);
        end else if (prdata !== {26'd0, (paddr[2] == CFG_PRG_UNITS) ? prg_units : chr_units}) begin
          $display("%0t: size register %0d read back expected %0d got %0d", $time,
                   paddr[2], (paddr[2] == CFG_PRG_UNITS) ? prg_units : chr_units, prdata);
          errors++;
        end
      end
      if (in_valid && !in_stall) begin
        pred = map_word(in_data);
        expected_words.push_back(cur_fixed_en ? cur_fixed : pred);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word %h arrived with nothing expected", $time, out_data);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          words_checked++;
          if (out_data.rom_address !== exp_w.rom_address) begin
            $display("%0t: rom_address expected %h got %h", $time,
                     exp_w.rom_address, out_data.rom_address);
            errors++;
          end
          if (out_data.mirror_vertical !== exp_w.mirror_vertical) begin
            $display("%0t: mirror_vertical expected %b got %b", $time,
                     exp_w.mirror_vertical, out_data.mirror_vertical);
            errors++;
          end
          if (out_data.accepted !== exp_w.accepted) begin
            $display("%0t: accepted expected %b got %b", $time,
                     exp_w.accepted, out_data.accepted);
            errors++;
          end
        end
      end
    end
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d words outstanding",
               cycles, expected_words.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: for every result word it holds stall high for a random gap, none in
  // flat-out stretches, then takes the next word that shows up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int gap;
    rx_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        rx_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      rx_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // One long hold-off on the result side while the sender keeps offering
  // words, so the block backs up and has to stall its input.
  initial begin : long_hold
    hold_off <= 1'b0;
    wait (start_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one word after a random gap and return at the edge that takes it.
  task automatic put_word(input in_word_t w, input logic fixed_en, input out_word_t fixed);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= w;
    cur_fixed_en <= fixed_en;
    cur_fixed    <= fixed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Each APB transfer ends with the bus idle so that back-to-back calls
  // never drive the bus twice in the same step.
  task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] data,
                         input logic fixed_en, input logic [18:0] rom, input logic mv,
                         input logic ok);
    dir_row_t r;
    r.word      = '{operation: op, address: addr, write_data: data};
    r.has_fixed = fixed_en;
    r.fixed     = '{rom_address: rom, mirror_vertical: mv, accepted: ok};
    dir_rows.push_back(r);
  endtask

  // Random words lean toward the mapper registers and in-range translates,
  // with a share of stray writes, out-of-range addresses and no-op words.
  function automatic in_word_t rand_word();
    in_word_t w;
    int sel;
    sel = $urandom_range(0, 99);
    w.write_data = 8'($urandom_range(0, 255));
    if (sel < 35) begin
      w.operation = OP_WRITE;
      w.address   = ADDR_CHR2K_0 + 16'($urandom_range(0, 12));
    end else if (sel < 40) begin
      w.operation = OP_WRITE;
      w.address   = 16'($urandom);
    end else if (sel < 65) begin
      w.operation = OP_CHR;
      w.address   = ($urandom_range(0, 7) != 0) ? {3'b000, 13'($urandom)} : 16'($urandom);
    end else if (sel < 95) begin
      w.operation = OP_PRG;
      w.address   = {($urandom_range(0, 7) != 0), 15'($urandom)};
    end else begin
      w.operation = OP_NONE;
      w.address   = 16'($urandom);
    end
    return w;
  endfunction

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [5:0] chr_set;
    logic [5:0] prg_set;
    int         sent;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cur_fixed_en <= 1'b0;
    cur_fixed    <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    sent         = 0;

    // Directed table, run against the reset sizes (16 and 16). The typed
    // rows are the out-of-range, ignored and reset-page cases and some register writes.
    add_row(OP_CHR,   16'h0000,     8'h00, 1, 19'h00000, 1, 1);
    add_row(OP_CHR,   16'h1FFF,     8'hA5, 1, 19'h01FFF, 1, 1);
    add_row(OP_CHR,   CHR_SPACE_END, 8'h00, 1, 19'h00000, 1, 0);
    add_row(OP_PRG,   16'h7FFF,     8'h00, 1, 19'h00000, 1, 0);
    add_row(OP_PRG,   16'h8000,     8'h00, 1, 19'h00000, 1, 1);
    add_row(OP_PRG,   16'hFFFF,     8'hFF, 1, 19'h3FFFF, 1, 1);
    add_row(OP_NONE,  16'h1234,     8'hFF, 1, 19'h00000, 1, 0);
    // Writes to the unused register gap and far outside it are ignored.
    add_row(OP_WRITE, 16'h7EF7,     8'hFF, 1, 19'h00000, 1, 0);
    add_row(OP_WRITE, 16'h7EF9,     8'hFF, 1, 19'h00000, 1, 0);
    add_row(OP_WRITE, 16'hFFFF,     8'h00, 1, 19'h00000, 1, 0);
    add_row(OP_WRITE, ADDR_CHR2K_0, 8'hFF, 1, 19'h00000, 1, 1);
    add_row(OP_WRITE, ADDR_CHR2K_1, 8'h05, 0, '0, 0, 0);
    add_row(OP_WRITE, ADDR_CHR1K_0, 8'h00, 0, '0, 0, 0);
    add_row(OP_WRITE, ADDR_CHR1K_1, 8'hFF, 0, '0, 0, 0);
    add_row(OP_WRITE, ADDR_CHR1K_2, 8'h80, 0, '0, 0, 0);
    add_row(OP_WRITE, ADDR_CHR1K_3, 8'h7F, 0, '0, 0, 0);
    add_row(OP_WRITE, ADDR_PRG_0,   8'hFF, 0, '0, 0, 0);
    add_row(OP_WRITE, ADDR_PRG_1,   8'h00, 0, '0, 0, 0);
    add_row(OP_WRITE, ADDR_PRG_2,   8'h83, 0, '0, 0, 0);
    add_row(OP_CHR,   16'h0400,     8'h00, 0, '0, 0, 0);
    add_row(OP_PRG,   16'hA000,     8'h00, 0, '0, 0, 0);
    // Swap the halves and select horizontal mirroring, then write a 2K bank
    // that now lands in the upper half.
    add_row(OP_WRITE, ADDR_CTRL,    8'h02, 1, 19'h00000, 0, 1);
    add_row(OP_WRITE, ADDR_CHR2K_0, 8'h11, 0, '0, 0, 0);
    add_row(OP_CHR,   16'h1000,     8'h00, 0, '0, 0, 0);
    add_row(OP_WRITE, ADDR_CTRL,    8'h01, 1, 19'h00000, 1, 1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      put_word(dir_rows[i].word, dir_rows[i].has_fixed, dir_rows[i].fixed);
      sent++;
    end
    in_valid <= 1'b0;
    drain();

    // Each phase sets both sizes and reads them back, then runs random
    // words. The settings walk one, 32, zero, all-ones and a mixed 16/1 pair
    // before three random ones.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin chr_set = 6'd1;  prg_set = 6'd1;  end
        1:       begin chr_set = 6'd32; prg_set = 6'd32; end
        2:       begin chr_set = 6'd0;  prg_set = 6'd0;  end
        3:       begin chr_set = 6'd63; prg_set = 6'd63; end
        4:       begin chr_set = 6'd16; prg_set = 6'd1;  end
        default: begin
          chr_set = 6'($urandom_range(1, 32));
          prg_set = 6'($urandom_range(1, 32));
        end
      endcase
      apb_xfer(1'b1, CFG_CHR_UNITS, {26'($urandom), chr_set});
      apb_xfer(1'b1, CFG_PRG_UNITS, {26'($urandom), prg_set});
      apb_xfer(1'b0, CFG_CHR_UNITS, 32'd0);
      apb_xfer(1'b0, CFG_PRG_UNITS, 32'd0);

      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        // Pacing is redrawn every 64 words so some stretches run flat out.
        if (n % 64 == 0) begin
          tx_idle = ($urandom_range(0, 3) != 0);
          rx_idle = ($urandom_range(0, 3) != 0);
        end
        if (ph == 1 && n == 20) start_hold = 1'b1;
        put_word(rand_word(), 1'b0, '0);
        sent++;
      end
      in_valid <= 1'b0;
      drain();
    end

    $display("Sent %0d words and checked %0d results over %0d size settings,",
             sent, words_checked, PHASES + 1);
    $display("covering bank writes, both translates, ignored words and a long output hold.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
